// File: src/jeoi_pkg.sv
// Shared types and constants for the JPEG end-of-image finder.
`timescale 1ns / 1ps

package jeoi_pkg;

   localparam int unsigned LEN_BITS = 24;
   localparam logic [LEN_BITS-1:0] MAX_FRAME_RESET = 24'd204800;

   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_SOI = 8'hD8;
   localparam logic [7:0] BYTE_EOI = 8'hD9;
   localparam logic [7:0] BYTE_SOS = 8'hDA;
   localparam logic [7:0] BYTE_TEM = 8'h01;
   localparam logic [7:0] BYTE_RST_LO = 8'hD0;
   localparam logic [7:0] BYTE_RST_HI = 8'hD7;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SOI1,
      PH_SOI2,
      PH_SEEK,
      PH_MARK,
      PH_LENH,
      PH_LENL,
      PH_SKIP,
      PH_SCAN,
      PH_SCANFF,
      PH_STUCK,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY       = 3'd0,
      ST_COMPLETE   = 3'd1,
      ST_BAD_START  = 3'd2,
      ST_OVERFLOW   = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_IGNORED    = 3'd5
   } status_type;

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      logic       command;
      logic       frame_start;
      logic       is_ff;
      logic       is_soi;
      logic       is_eoi;
      logic       is_sos;
      logic       no_length;
      logic [7:0] data_byte;
   } class_type;

endpackage

// File: src/jeoi_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface jeoi_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, command, data_byte, frame_start, input ready);
   modport sink (input valid, command, data_byte, frame_start, output ready);
endinterface

interface jeoi_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [23:0] image_length;
   logic        in_entropy_data;

   modport source (output valid, status, image_length, in_entropy_data, input ready);
   modport sink (input valid, status, image_length, in_entropy_data, output ready);
endinterface

// File: src/jpeg_end_of_image_finder.sv
// Top level of the JPEG end-of-image finder.
// Usage: camera bytes enter on req_bus, one request per byte (command 0) or a
// frame-end request (command 1); frame_start marks the first byte of a frame.
// Every request yields exactly one response on rsp_bus with status, the image
// length (nonzero only on complete) and the entropy-data flag.
// csr_wr_en/csr_wr_data set the buffer capacity in bytes; write it only
// while no requests are outstanding.
// Flow: a request is classified combinationally and queued when accepted, then
// runs through the parser step into the response register that drives rsp_bus.
// Throughput: one request per cycle while rsp_bus.ready is high.
// Reset: parser idle, capacity 204800, queue and response register empty.
// Stall: when rsp_bus.ready is low the response register holds, the
// two-entry queue fills, and req_bus.ready drops once it is full.
`timescale 1ns / 1ps

module jpeg_end_of_image_finder #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   jeoi_req_if.sink    req_bus,
   jeoi_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   jeoi_pkg::class_type push_item, pop_item;

   jeoi_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   jeoi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   jeoi_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_bus     (rsp_bus)
   );

endmodule

// File: src/jeoi_front.sv
// Front end: accepts requests and classifies the byte.
`timescale 1ns / 1ps

module jeoi_front (
   jeoi_req_if.sink            req_bus,
   output logic                push_valid,
   input  logic                push_ready,
   output jeoi_pkg::class_type push_item
);

   assign req_bus.ready = push_ready;
   assign push_valid = req_bus.valid;

   always_comb begin
      push_item.command = req_bus.command;
      push_item.frame_start = req_bus.frame_start;
      push_item.data_byte = req_bus.data_byte;
      push_item.is_ff = (req_bus.data_byte == jeoi_pkg::BYTE_FF);
      push_item.is_soi = (req_bus.data_byte == jeoi_pkg::BYTE_SOI);
      push_item.is_eoi = (req_bus.data_byte == jeoi_pkg::BYTE_EOI);
      push_item.is_sos = (req_bus.data_byte == jeoi_pkg::BYTE_SOS);
      push_item.no_length = (req_bus.data_byte == jeoi_pkg::BYTE_SOI)
                         || (req_bus.data_byte == jeoi_pkg::BYTE_TEM)
                         || ((req_bus.data_byte >= jeoi_pkg::BYTE_RST_LO)
                             && (req_bus.data_byte <= jeoi_pkg::BYTE_RST_HI));
   end

endmodule

// File: src/jeoi_queue.sv
// Two-entry queue between front and back.
`timescale 1ns / 1ps

module jeoi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  jeoi_pkg::class_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output jeoi_pkg::class_type pop_item
);

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_BITS = $clog2(DEPTH);

   jeoi_pkg::class_type slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (PTR_BITS+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/jeoi_back.sv
// Back end: marker walk, byte count, capacity check and response register.
`timescale 1ns / 1ps

module jeoi_back #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [23:0]         csr_wr_data,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  jeoi_pkg::class_type pop_item,
   jeoi_rsp_if.source          rsp_bus
);

   localparam int unsigned WIDE_BITS =
      (COUNT_BITS > jeoi_pkg::LEN_BITS) ? COUNT_BITS : jeoi_pkg::LEN_BITS;

   jeoi_pkg::phase_type  phase_ff, phase_in;
   logic [COUNT_BITS-1:0] seen_ff, seen_in;
   logic [15:0]          left_ff, left_in;
   logic [7:0]           len_hi_ff, len_hi_in;
   logic                 scan_ff, scan_in;
   logic [23:0]          max_bytes_ff;

   logic                 out_valid_ff, out_valid_in;
   jeoi_pkg::status_type out_status_ff, out_status_in;
   logic [23:0]          out_len_ff, out_len_in;
   logic                 out_ent_ff, out_ent_in;

   jeoi_pkg::phase_type  ph, mid_phase;
   logic [COUNT_BITS-1:0] seen, seen_inc;
   logic [15:0]          left, left_mid;
   logic [7:0]           len_hi, len_hi_mid;
   logic                 scan, scan_mid;
   logic                 fire, ignored, done, bad, over;
   logic [WIDE_BITS-1:0] seen_wide;

   assign pop_ready = !out_valid_ff || rsp_bus.ready;
   assign fire = pop_valid && pop_ready;

   // frame start restarts the parser before the request is handled
   always_comb begin
      ph = pop_item.frame_start ? jeoi_pkg::PH_SOI1 : phase_ff;
      seen = pop_item.frame_start ? '0 : seen_ff;
      left = pop_item.frame_start ? '0 : left_ff;
      len_hi = pop_item.frame_start ? '0 : len_hi_ff;
      scan = pop_item.frame_start ? 1'b0 : scan_ff;
      ignored = (ph == jeoi_pkg::PH_IDLE) || (ph == jeoi_pkg::PH_DONE);
      seen_inc = (seen == '1) ? seen : seen + 1'b1;
      seen_wide = WIDE_BITS'(seen_inc);
      over = (seen_wide >= WIDE_BITS'(max_bytes_ff)) || (seen_inc == '1);
   end

   // one data byte through the marker walk
   always_comb begin
      logic [15:0] seg_len;
      seg_len = {len_hi, pop_item.data_byte};
      mid_phase = ph;
      left_mid = left;
      len_hi_mid = len_hi;
      scan_mid = scan;
      done = 1'b0;
      bad = 1'b0;
      case (ph)
         jeoi_pkg::PH_SOI1: begin
            if (pop_item.is_ff) mid_phase = jeoi_pkg::PH_SOI2;
            else bad = 1'b1;
         end
         jeoi_pkg::PH_SOI2: begin
            if (pop_item.is_soi) mid_phase = jeoi_pkg::PH_SEEK;
            else bad = 1'b1;
         end
         jeoi_pkg::PH_SEEK: begin
            if (pop_item.is_ff) mid_phase = jeoi_pkg::PH_MARK;
         end
         jeoi_pkg::PH_MARK: begin
            if (pop_item.is_ff) begin
               mid_phase = jeoi_pkg::PH_MARK;
            end else if (pop_item.no_length) begin
               mid_phase = jeoi_pkg::PH_SEEK;
            end else begin
               scan_mid = pop_item.is_sos;
               mid_phase = jeoi_pkg::PH_LENH;
            end
         end
         jeoi_pkg::PH_LENH: begin
            len_hi_mid = pop_item.data_byte;
            mid_phase = jeoi_pkg::PH_LENL;
         end
         jeoi_pkg::PH_LENL: begin
            if (seg_len < 16'd2) begin
               mid_phase = jeoi_pkg::PH_STUCK;
            end else begin
               left_mid = seg_len - 16'd2;
               if (left_mid == '0) begin
                  mid_phase = scan ? jeoi_pkg::PH_SCAN : jeoi_pkg::PH_SEEK;
               end else begin
                  mid_phase = jeoi_pkg::PH_SKIP;
               end
            end
         end
         jeoi_pkg::PH_SKIP: begin
            if (left != '0) left_mid = left - 1'b1;
            if (left_mid == '0) begin
               mid_phase = scan ? jeoi_pkg::PH_SCAN : jeoi_pkg::PH_SEEK;
            end
         end
         jeoi_pkg::PH_SCAN: begin
            if (pop_item.is_ff) mid_phase = jeoi_pkg::PH_SCANFF;
         end
         jeoi_pkg::PH_SCANFF: begin
            if (pop_item.is_eoi) done = 1'b1;
            else mid_phase = jeoi_pkg::PH_SCAN;
         end
         default: begin
            mid_phase = ph;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      seen_in = seen_ff;
      left_in = left_ff;
      len_hi_in = len_hi_ff;
      scan_in = scan_ff;
      if (fire && !ignored) begin
         seen_in = seen;
         left_in = left;
         len_hi_in = len_hi;
         scan_in = scan;
         if (pop_item.command) begin
            phase_in = jeoi_pkg::PH_DONE;
         end else begin
            seen_in = seen_inc;
            left_in = left_mid;
            len_hi_in = len_hi_mid;
            scan_in = scan_mid;
            phase_in = (done || bad || over) ? jeoi_pkg::PH_DONE : mid_phase;
         end
      end
   end

   // response fields
   always_comb begin
      out_valid_in = out_valid_ff;
      out_status_in = out_status_ff;
      out_len_in = out_len_ff;
      out_ent_in = out_ent_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (fire) begin
         out_valid_in = 1'b1;
         out_len_in = '0;
         out_ent_in = 1'b0;
         if (ignored) begin
            out_status_in = jeoi_pkg::ST_IGNORED;
         end else if (pop_item.command) begin
            out_status_in = jeoi_pkg::ST_INCOMPLETE;
            out_ent_in = (ph == jeoi_pkg::PH_SCAN) || (ph == jeoi_pkg::PH_SCANFF);
         end else begin
            out_ent_in = (mid_phase == jeoi_pkg::PH_SCAN)
                      || (mid_phase == jeoi_pkg::PH_SCANFF);
            if (done) begin
               out_status_in = jeoi_pkg::ST_COMPLETE;
               out_len_in = seen_wide[23:0];
               out_ent_in = 1'b1;
            end else if (bad) begin
               out_status_in = jeoi_pkg::ST_BAD_START;
            end else if (over) begin
               out_status_in = jeoi_pkg::ST_OVERFLOW;
            end else begin
               out_status_in = jeoi_pkg::ST_BUSY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jeoi_pkg::PH_IDLE;
         seen_ff <= '0;
         left_ff <= '0;
         len_hi_ff <= '0;
         scan_ff <= 1'b0;
         max_bytes_ff <= jeoi_pkg::MAX_FRAME_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seen_ff <= seen_in;
         left_ff <= left_in;
         len_hi_ff <= len_hi_in;
         scan_ff <= scan_in;
         if (csr_wr_en) max_bytes_ff <= csr_wr_data;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_len_ff <= out_len_in;
      out_ent_ff <= out_ent_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.status = out_status_ff;
   assign rsp_bus.image_length = out_len_ff;
   assign rsp_bus.in_entropy_data = out_ent_ff;

endmodule
